### rtl/triangle_barycentric_coords_macros.svh
// assertion macros shared by the barycentric block
`ifndef TRIANGLE_BARYCENTRIC_COORDS_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_MACROS_SVH

// same-cycle implication, disabled in reset
`define TBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tbc_pkg.sv
// shared types and constants of the barycentric block
`default_nettype none
package tbc_pkg;

  // width of one output weight
  localparam int WEIGHT_W = 32;

  // one finished result
  typedef struct packed {
    logic                       degenerate;
    logic signed [WEIGHT_W-1:0] weight_w;
    logic signed [WEIGHT_W-1:0] weight_v;
    logic signed [WEIGHT_W-1:0] weight_u;
  } result_t;

  // dot products feeding the six wide multiplies: operand a and operand b
  localparam int unsigned MUL_OPA [6] = '{0, 1, 2, 1, 0, 1};
  localparam int unsigned MUL_OPB [6] = '{2, 1, 3, 4, 4, 3};

endpackage
`default_nettype wire

### rtl/tbc_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module tbc_div #(
  parameter int TW  = 129,
  parameter int DVW = 104
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [TW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic      [TW-1:0]  quotient
);
  import tbc_pkg::*;

  // per-stage registers: dividend bits shift out while quotient bits shift in
  logic [TW-1:0]  word [TW];
  logic [DVW-1:0] rem  [TW];
  logic [DVW-1:0] dvs  [TW];

  for (genvar k = 0; k < TW; k++) begin : g_stage
    logic [TW-1:0]  w_prev;
    logic [DVW-1:0] r_prev;
    logic [DVW-1:0] d_prev;
    logic [DVW:0]   r2;
    logic           qbit;
    logic [DVW-1:0] r_next;

    if (k == 0) begin : g_first
      assign w_prev = dividend;
      assign r_prev = '0;
      assign d_prev = divisor;
    end else begin : g_rest
      assign w_prev = word[k-1];
      assign r_prev = rem[k-1];
      assign d_prev = dvs[k-1];
    end

    // one compare and subtract
    always_comb begin
      r2     = {r_prev, w_prev[TW-1]};
      qbit   = (r2 >= {1'b0, d_prev});
      r_next = qbit ? DVW'(r2 - {1'b0, d_prev}) : r2[DVW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        word[k] <= {w_prev[TW-2:0], qbit};
        rem[k]  <= r_next;
        dvs[k]  <= d_prev;
      end
    end
  end

  assign quotient = word[TW-1];

endmodule
`default_nettype wire

### rtl/triangle_barycentric_coords.sv
// barycentric weights of a point against a 3d triangle, fully pipelined
//
//  channel  dir  payload (lowest bits first)                    handshake
//  s_*      in   a_x a_y a_z b_x b_y b_z c_x c_y c_z p_x p_y p_z tvalid/tready
//  m_*      out  tdata: weight_u weight_v weight_w; tuser: degen  tvalid/tready
//
// one transaction enters per cycle while s_tready is high; most of the pipeline
// depth lies in the two bit-per-stage divider pipelines.
// rst clears the valid bits only; payload registers hold whatever they had.
// a stalled output parks one result in a skid register; s_tready drops only
// while that skid register is full, and the whole pipeline holds with it.
`default_nettype none
`include "triangle_barycentric_coords_macros.svh"
module triangle_barycentric_coords #(
  parameter int COORD_WIDTH   = 24,
  parameter int OUT_FRAC_BITS = 24
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  // a_x a_y a_z b_x b_y b_z c_x c_y c_z p_x p_y p_z, zero pad to bytes
  input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  // weight_u weight_v weight_w
  output logic [3*tbc_pkg::WEIGHT_W-1:0]               m_tdata,
  // degenerate
  output logic [0:0]                                   m_tuser
);
  import tbc_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int F   = OUT_FRAC_BITS;
  localparam int EW  = CW + 1;          // edge vector component
  localparam int PW  = 2 * EW;          // component product
  localparam int DW  = 2 * CW + 3;      // dot product
  localparam int HL  = (DW + 1) / 2;    // half of a split dot product
  localparam int BW  = 2 * DW;          // dot times dot
  localparam int NW  = BW + 1;          // numerator / determinant
  localparam int TW  = NW + F + 2;      // scaled dividend
  localparam int DVW = NW + 1;          // doubled divisor
  localparam int SW  = TW + 2;          // signed quotient sum

  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign s_tready = en;

  // stage valid bits
  logic [6:0]    vld;
  logic [TW-1:0] vld_div;
  logic          vld_f1, vld_f2;

  // unpack coordinates
  logic signed [CW-1:0] fin [12];
  always_comb begin
    for (int k = 0; k < 12; k++) fin[k] = s_tdata[k*CW +: CW];
  end

  // stage 1: edge vectors
  logic signed [EW-1:0] e0 [3], e1 [3], e2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e0[k] <= EW'(fin[3+k]) - EW'(fin[k]);
        e1[k] <= EW'(fin[6+k]) - EW'(fin[k]);
        e2[k] <= EW'(fin[9+k]) - EW'(fin[k]);
      end
    end
  end

  // stage 2: component products, groups e0e0 e0e1 e1e1 e2e0 e2e1
  logic signed [PW-1:0] pr [15];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr[k]    <= e0[k] * e0[k];
        pr[3+k]  <= e0[k] * e1[k];
        pr[6+k]  <= e1[k] * e1[k];
        pr[9+k]  <= e2[k] * e0[k];
        pr[12+k] <= e2[k] * e1[k];
      end
    end
  end

  // stage 3: dot products d00 d01 d11 d20 d21
  logic signed [DW-1:0] dp [5];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 5; g++) begin
        dp[g] <= DW'(pr[3*g]) + DW'(pr[3*g+1]) + DW'(pr[3*g+2]);
      end
    end
  end

  // stage 4: partial products of the six wide multiplies
  logic        [2*HL-1:0] pp_ll [6];
  logic signed [2*HL:0]   pp_lh [6], pp_hl [6];
  logic signed [2*HL-1:0] pp_hh [6];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        logic signed [2*HL-1:0] xa, xb;
        logic signed [HL:0]     al, bl;
        logic signed [HL-1:0]   ah, bh;
        xa = (2*HL)'(dp[MUL_OPA[j]]);
        xb = (2*HL)'(dp[MUL_OPB[j]]);
        al = $signed({1'b0, xa[HL-1:0]});
        bl = $signed({1'b0, xb[HL-1:0]});
        ah = xa[2*HL-1:HL];
        bh = xb[2*HL-1:HL];
        pp_ll[j] <= xa[HL-1:0] * xb[HL-1:0];
        pp_lh[j] <= al * bh;
        pp_hl[j] <= ah * bl;
        pp_hh[j] <= ah * bh;
      end
    end
  end

  // stage 5: recombine partial products
  logic signed [BW-1:0] prod [6];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        logic signed [4*HL-1:0] s;
        s = ((4*HL)'(pp_hh[j]) <<< (2*HL))
          + (((4*HL)'(pp_lh[j]) + (4*HL)'(pp_hl[j])) <<< HL)
          + $signed({{(2*HL){1'b0}}, pp_ll[j]});
        prod[j] <= s[BW-1:0];
      end
    end
  end

  // stage 6: determinant and the two numerators
  logic signed [NW-1:0] den, nv, nw;
  always_ff @(posedge clk) begin
    if (en) begin
      den <= NW'(prod[0]) - NW'(prod[1]);
      nv  <= NW'(prod[2]) - NW'(prod[3]);
      nw  <= NW'(prod[4]) - NW'(prod[5]);
    end
  end

  // stage 7: magnitudes, rounding offset, signs
  logic [TW-1:0]  top_v, top_w;
  logic [DVW-1:0] dvs;
  logic           neg_v7, neg_w7, deg7;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [NW-1:0] an_v, an_w, ad;
      an_v = nv[NW-1]  ? NW'(-nv)  : NW'(nv);
      an_w = nw[NW-1]  ? NW'(-nw)  : NW'(nw);
      ad   = den[NW-1] ? NW'(-den) : NW'(den);
      top_v  <= (TW'(an_v) << (F + 1)) + TW'(ad);
      top_w  <= (TW'(an_w) << (F + 1)) + TW'(ad);
      dvs    <= {ad, 1'b0};
      neg_v7 <= nv[NW-1] ^ den[NW-1];
      neg_w7 <= nw[NW-1] ^ den[NW-1];
      deg7   <= (den == '0);
    end
  end

  // divider pipelines
  logic [TW-1:0] quo_v, quo_w;
  tbc_div #(.TW(TW), .DVW(DVW)) u_div_v (
    .clk(clk), .en(en), .dividend(top_v), .divisor(dvs), .quotient(quo_v)
  );
  tbc_div #(.TW(TW), .DVW(DVW)) u_div_w (
    .clk(clk), .en(en), .dividend(top_w), .divisor(dvs), .quotient(quo_w)
  );

  // side bits travel alongside the dividers
  logic [TW-1:0] sd_neg_v, sd_neg_w, sd_deg;
  always_ff @(posedge clk) begin
    if (en) begin
      sd_neg_v <= {sd_neg_v[TW-2:0], neg_v7};
      sd_neg_w <= {sd_neg_w[TW-2:0], neg_w7};
      sd_deg   <= {sd_deg[TW-2:0], deg7};
    end
  end

  // finish 1: apply signs
  logic signed [TW:0] qv, qw;
  logic               deg_f1;
  always_ff @(posedge clk) begin
    if (en) begin
      qv     <= sd_neg_v[TW-1] ? -$signed({1'b0, quo_v}) : $signed({1'b0, quo_v});
      qw     <= sd_neg_w[TW-1] ? -$signed({1'b0, quo_w}) : $signed({1'b0, quo_w});
      deg_f1 <= sd_deg[TW-1];
    end
  end

  // clamp to the output weight range
  function automatic logic signed [WEIGHT_W-1:0] sat(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] hi, lo;
    hi = SW'({1'b0, {(WEIGHT_W-1){1'b1}}});
    lo = -hi - SW'(1);
    if (x > hi)      sat = hi[WEIGHT_W-1:0];
    else if (x < lo) sat = lo[WEIGHT_W-1:0];
    else             sat = x[WEIGHT_W-1:0];
  endfunction

  // finish 2: u from the rounded v and w, saturate, degenerate override
  result_t res_f2;
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [SW-1:0] qu;
      qu = (SW'(1) <<< F) - SW'(qv) - SW'(qw);
      res_f2.degenerate <= deg_f1;
      res_f2.weight_u   <= deg_f1 ? '0 : sat(qu);
      res_f2.weight_v   <= deg_f1 ? '0 : sat(SW'(qv));
      res_f2.weight_w   <= deg_f1 ? '0 : sat(SW'(qw));
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      vld_div <= '0;
      vld_f1  <= 1'b0;
      vld_f2  <= 1'b0;
    end else if (en) begin
      vld     <= {vld[5:0], s_tvalid};
      vld_div <= {vld_div[TW-2:0], vld[6]};
      vld_f1  <= vld_div[TW-1];
      vld_f2  <= vld_f1;
    end
  end

  // output register with one skid entry
  result_t out_r, skid_r;
  logic    push, pop;
  assign push = en && vld_f2;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || pop) begin
      m_tvalid   <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || pop) begin
      out_r <= skid_valid ? skid_r : res_f2;
    end else if (push) begin
      skid_r <= res_f2;
    end
  end

  assign m_tdata    = {out_r.weight_w, out_r.weight_v, out_r.weight_u};
  assign m_tuser[0] = out_r.degenerate;

  `TBC_ASSERT_NOW(a_deg_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata == '0, "degenerate result with nonzero weights")
  `TBC_ASSERT_NOW(a_skid_has_out, clk, rst, skid_valid, m_tvalid, "skid entry held behind an empty output")
  `TBC_ASSERT_NEXT(a_skid_fill, clk, rst, push && m_tvalid && !m_tready, skid_valid, "result lost while output stalled")
  `TBC_ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && pop, !skid_valid && m_tvalid, "skid entry not moved to output")

endmodule
`default_nettype wire

### tb/triangle_barycentric_coords_test.sv
// self-checking testbench for the barycentric weight pipeline
`timescale 1ns / 100ps
`default_nettype none
module triangle_barycentric_coords_test;
  import tbc_pkg::*;

  localparam int CW = 24;
  localparam int FRAC = 24;
  localparam int NUM_RANDOM = 700;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 3000;
  localparam int ONE = 4096;
  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;

  typedef logic signed [255:0] wide_t;
  typedef logic [12*CW-1:0] item_t;

  // one directed row: twelve coordinates, optional typed-in answer
  typedef struct {
    item_t   item;
    bit      has_answer;
    result_t answer;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [12*CW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [3*WEIGHT_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  result_t pending_weights[$];
  row_t directed_rows[$];
  int errors = 0;
  int idle_cycles = 0;

  triangle_barycentric_coords dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // pack twelve coordinates, corner a first
  function automatic item_t make_item(input int v[12]);
    item_t it;
    it = '0;
    for (int k = 0; k < 12; k++) it[CW*k +: CW] = v[k][CW-1:0];
    return it;
  endfunction

  // num * 2^FRAC / den, nearest, ties away from zero
  function automatic wide_t round_quotient(input wide_t num, input wide_t den);
    wide_t an, ad, q;
    bit neg;
    neg = num[255] ^ den[255];
    an = num[255] ? -num : num;
    ad = den[255] ? -den : den;
    q = ((an <<< (FRAC + 1)) + ad) / (ad <<< 1);
    return neg ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp_weight(input wide_t x);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< 31) - 1;
    lo = -(wide_t'(1) <<< 31);
    if (x > hi) return 32'h7fffffff;
    if (x < lo) return 32'h80000000;
    return x[31:0];
  endfunction

  // exact barycentric weights of the projected point
  function automatic result_t predict_weights(input item_t it);
    wide_t a, e0[3], e1[3], e2[3];
    wide_t d00, d01, d11, d20, d21, den, nv, nw, qv, qw, qu;
    result_t r;
    for (int k = 0; k < 3; k++) begin
      a = $signed(it[CW*k +: CW]);
      e0[k] = wide_t'($signed(it[CW*(3+k) +: CW])) - a;
      e1[k] = wide_t'($signed(it[CW*(6+k) +: CW])) - a;
      e2[k] = wide_t'($signed(it[CW*(9+k) +: CW])) - a;
    end
    d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
    d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
    d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    d20 = e2[0]*e0[0] + e2[1]*e0[1] + e2[2]*e0[2];
    d21 = e2[0]*e1[0] + e2[1]*e1[1] + e2[2]*e1[2];
    den = d00*d11 - d01*d01;
    r = '0;
    if (den == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    nv = d11*d20 - d01*d21;
    nw = d00*d21 - d01*d20;
    qv = round_quotient(nv, den);
    qw = round_quotient(nw, den);
    qu = (wide_t'(1) <<< FRAC) - qv - qw;
    r.weight_u = clamp_weight(qu);
    r.weight_v = clamp_weight(qv);
    r.weight_w = clamp_weight(qw);
    return r;
  endfunction

  // random item: mostly full range, some small triangles, some collinear
  function automatic item_t random_item();
    int v[12];
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 12; k++) begin
      if (mode < 6) v[k] = $signed($urandom());
      else v[k] = int'($urandom_range(0, 16384)) - 8192;
    end
    if (mode >= 8) begin
      for (int k = 0; k < 3; k++) v[6+k] = 2*v[3+k] - v[k];
    end
    return make_item(v);
  endfunction

  // append one row to the directed table
  task automatic add_row(input item_t it, input bit has_answer, input result_t answer);
    row_t row;
    row.item = it;
    row.has_answer = has_answer;
    row.answer = answer;
    directed_rows = {directed_rows, row};
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // hand one transaction to the block after a random gap, or with no gap in a burst
  task automatic send_item(input item_t it, input result_t answer, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= it;
    do @(posedge clk); while (!s_tready);
    pending_weights = {pending_weights, answer};
  endtask

  // check every accepted result against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("result count", 1, 0);
      end else begin
        want = pending_weights[0];
        pending_weights.delete(0);
        if ($signed(m_tdata[31:0]) != want.weight_u)
          report_mismatch("weight_u", $signed(m_tdata[31:0]), want.weight_u);
        if ($signed(m_tdata[63:32]) != want.weight_v)
          report_mismatch("weight_v", $signed(m_tdata[63:32]), want.weight_v);
        if ($signed(m_tdata[95:64]) != want.weight_w)
          report_mismatch("weight_w", $signed(m_tdata[95:64]), want.weight_w);
        if (m_tuser[0] != want.degenerate)
          report_mismatch("degenerate", m_tuser[0], want.degenerate);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("triangle_barycentric_coords regression: fail");
      $finish;
    end
  end

  // receiver with random stalls and occasional bursts
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    result_t r;
    row_t row;
    bit burst;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // degenerate triangles
    r = '0;
    r.degenerate = 1'b1;
    add_row(make_item('{0,0,0, 0,0,0, 0,0,0, 0,0,0}), 1'b1, r);
    add_row(make_item('{CMAX,CMAX,CMAX, CMAX,CMAX,CMAX,
                        CMAX,CMAX,CMAX, CMAX,CMAX,CMAX}), 1'b1, r);
    add_row(make_item('{CMIN,CMIN,CMIN, CMIN,CMIN,CMIN,
                        CMIN,CMIN,CMIN, CMIN,CMIN,CMIN}), 1'b1, r);
    add_row(make_item('{0,0,0, ONE,ONE,ONE, 2*ONE,2*ONE,2*ONE,
                        1,2,3}), 1'b1, r);
    // point on each corner of a unit triangle
    r = '0;
    r.weight_u = 32'sd1 <<< FRAC;
    add_row(make_item('{0,0,0, ONE,0,0, 0,ONE,0, 0,0,0}), 1'b1, r);
    r = '0;
    r.weight_v = 32'sd1 <<< FRAC;
    add_row(make_item('{0,0,0, ONE,0,0, 0,ONE,0, ONE,0,0}), 1'b1, r);
    r = '0;
    r.weight_w = 32'sd1 <<< FRAC;
    add_row(make_item('{0,0,0, ONE,0,0, 0,ONE,0, 0,ONE,0}), 1'b1, r);
    // predicted rows: inside, saturating, off plane, extreme corners
    add_row(make_item('{0,0,0, 3*ONE,0,0, 0,3*ONE,0, ONE,ONE,0}), 1'b0, r);
    add_row(make_item('{0,0,0, 1,0,0, 0,1,0, CMAX,CMAX,CMAX}), 1'b0, r);
    add_row(make_item('{0,0,0, 1,0,0, 0,1,0, CMIN,CMIN,CMIN}), 1'b0, r);
    add_row(make_item('{CMAX,CMIN,CMAX, CMIN,CMAX,CMIN,
                        CMAX,CMAX,CMIN, CMIN,CMIN,CMAX}), 1'b0, r);
    add_row(make_item('{0,0,0, ONE,0,0, 0,ONE,0, 1000,1000,CMAX}), 1'b0, r);
    add_row(make_item('{0,0,0, ONE,0,0, 0,ONE,0, -ONE,-ONE,5}), 1'b0, r);
    add_row(make_item('{-5,7,-9, 3,CMAX,1, CMIN,4,-2, 0,-1,CMAX}), 1'b0, r);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_item(row.item, row.has_answer ? row.answer : predict_weights(row.item), 1'b0);
    end

    burst = 1'b0;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      item_t it;
      if (n % 50 == 0) burst = ($urandom_range(0, 2) == 0);
      // hold off until the pipeline has drained completely
      if (n == NUM_RANDOM / 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_weights.size() != 0) @(posedge clk);
      end
      it = random_item();
      send_item(it, predict_weights(it), burst);
    end
    s_tvalid <= 1'b0;

    while (pending_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("triangle_barycentric_coords regression: pass");
    else $display("triangle_barycentric_coords regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/tbc_pkg.sv
rtl/tbc_div.sv
rtl/triangle_barycentric_coords.sv
tb/triangle_barycentric_coords_test.sv
